### rtl/thermo_pkg.sv
// Package for the thermostat setpoint and heater control block.
// Holds the tick item type, register indexes and reset constants.
// No dependencies.
package thermo_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_MIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_MAX = 2'd2;

    // Reset values
    localparam logic [7:0] SENSITIVITY_RST  = 8'd10;
    localparam logic [7:0] SETPOINT_MIN_RST = 8'd8;
    localparam logic [7:0] SETPOINT_MAX_RST = 8'd66;
    localparam logic [7:0] SETPOINT_RST     = 8'd40;   // 20.0 degrees

    // One control tick
    typedef struct packed {
        logic               down_press;
        logic               up_press;
        logic               sensor_valid;
        logic signed [15:0] sensor_reading;
    } tick_t;

endpackage

### rtl/thermostat_setpoint_and_heater_control.sv
// Bang-bang thermostat with button-driven setpoint and remote lock flag.
// Each tick passes through the input register, then the state and result
// register. Throughput: one tick per cycle while the result side does not
// stall. Reset clears all control state, loads the default setpoint (20.0
// degrees) and the default config registers.
// Depends on thermo_pkg.
module thermostat_setpoint_and_heater_control (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thermo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                          cfg_data,
    // tick input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                down_press,
    input  logic                                up_press,
    input  logic                                sensor_valid,
    input  logic signed [15:0]                  sensor_reading,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                heater,
    output logic                                report,
    output logic [7:0]                          setpoint,
    output logic signed [15:0]                  ambient,
    output logic                                remote_lock
);
    import thermo_pkg::*;

    // Configuration registers
    logic [7:0] sensitivity_reg;
    logic [7:0] setpoint_min_reg;
    logic [7:0] setpoint_max_reg;

    // Input stage
    tick_t      item_reg;
    logic       item_valid_reg;

    // State, doubling as the result register
    logic [7:0]         setpoint_reg, setpoint_next;
    logic signed [15:0] ambient_reg, ambient_next;
    logic               heater_reg, heater_next;
    logic               lock_reg, lock_next;
    logic               first_seen_reg, first_seen_next;
    logic               report_reg, report_next;
    logic               out_valid_reg;

    logic               advance;

    // Scratch signals for the tick logic
    logic signed [9:0]  step_sum;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic signed [16:0] target;
    logic               sp_changed;
    logic               rd_taken;
    logic               heater_changed;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;

    // Configuration writes; index 3 is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensitivity_reg  <= SENSITIVITY_RST;
            setpoint_min_reg <= SETPOINT_MIN_RST;
            setpoint_max_reg <= SETPOINT_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SENSITIVITY:  sensitivity_reg  <= cfg_data;
                CFG_SETPOINT_MIN: setpoint_min_reg <= cfg_data;
                CFG_SETPOINT_MAX: setpoint_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.down_press     <= down_press;
            item_reg.up_press       <= up_press;
            item_reg.sensor_valid   <= sensor_valid;
            item_reg.sensor_reading <= sensor_reading;
        end
    end

    // Tick logic: buttons, reading filter, heater hysteresis-free compare
    always_comb
    begin
        setpoint_next   = setpoint_reg;
        lock_next       = lock_reg;
        ambient_next    = ambient_reg;
        first_seen_next = first_seen_reg;
        heater_next     = heater_reg;
        sp_changed      = 1'b0;
        rd_taken        = 1'b0;
        heater_changed  = 1'b0;

        // setpoint step, min clamp wins over max clamp
        step_sum = $signed({2'b00, setpoint_reg})
                 + (item_reg.down_press ? 10'sd1 * -10'sd1 : 10'sd1);
        if (item_reg.down_press && item_reg.up_press)
        begin
            lock_next = !lock_reg;
        end
        else if (item_reg.down_press || item_reg.up_press)
        begin
            if (step_sum < $signed({2'b00, setpoint_min_reg}))
            begin
                setpoint_next = setpoint_min_reg;
            end
            else if (step_sum > $signed({2'b00, setpoint_max_reg}))
            begin
                setpoint_next = setpoint_max_reg;
            end
            else
            begin
                setpoint_next = step_sum[7:0];
            end
            sp_changed = (setpoint_next != setpoint_reg);
        end

        // reading accepted only when it moved by more than the sensitivity
        diff     = {ambient_reg[15], ambient_reg}
                 - {item_reg.sensor_reading[15], item_reg.sensor_reading};
        diff_mag = diff[16] ? 17'(-diff) : 17'(diff);
        if (item_reg.sensor_valid && (diff_mag > {9'd0, sensitivity_reg}))
        begin
            ambient_next    = item_reg.sensor_reading;
            first_seen_next = 1'b1;
            rd_taken        = 1'b1;
        end

        // heater: on below setpoint*64, off above, hold when equal
        target = $signed({3'b000, setpoint_next, 6'd0});
        if ($signed({ambient_next[15], ambient_next}) < target)
        begin
            heater_next = 1'b1;
        end
        else if ($signed({ambient_next[15], ambient_next}) > target)
        begin
            heater_next = 1'b0;
        end
        heater_changed = (heater_next != heater_reg);

        report_next = first_seen_next
                   && ((item_reg.down_press && item_reg.up_press)
                       || sp_changed || rd_taken || heater_changed);
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= SETPOINT_RST;
            ambient_reg    <= '0;
            heater_reg     <= 1'b0;
            lock_reg       <= 1'b0;
            first_seen_reg <= 1'b0;
            report_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                setpoint_reg   <= setpoint_next;
                ambient_reg    <= ambient_next;
                heater_reg     <= heater_next;
                lock_reg       <= lock_next;
                first_seen_reg <= first_seen_next;
                report_reg     <= report_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign heater      = heater_reg;
    assign report      = report_reg;
    assign setpoint    = setpoint_reg;
    assign ambient     = ambient_reg;
    assign remote_lock = lock_reg;

`ifndef ASSERT_OFF
    // a report is only sent after a first reading
    a_report_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && report_reg |-> first_seen_reg)
        else $error("report without first reading");

    // a held item is never dropped while the result side stalls
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("input item lost");

    // state does not move while a result waits
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(setpoint_reg) && $stable(ambient_reg)
                                        && $stable(heater_reg) && $stable(lock_reg))
        else $error("state changed under a stalled result");

    // heater on whenever the accepted reading is below the setpoint
    a_heater_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ($signed({ambient_reg[15], ambient_reg})
                          < $signed({3'b000, setpoint_reg, 6'd0})) |-> heater_reg)
        else $error("heater off below setpoint");
`endif

endmodule

### dv/thermostat_setpoint_and_heater_control_tb.sv
// Self-checking testbench for the thermostat setpoint and heater control block.
// Drives tick and register write transactions and checks every status result.
// Depends on thermo_pkg and thermostat_setpoint_and_heater_control.
`timescale 1ns / 100ps

module thermostat_setpoint_and_heater_control_tb;

    import thermo_pkg::*;

    // Index 3 is decoded by nobody; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 28;
    localparam int HOLD_CYCLES = 300;

    // Status expected after one tick
    typedef struct packed {
        logic               heater;
        logic               report;
        logic [7:0]         setpoint;
        logic signed [15:0] ambient;
        logic               remote_lock;
    } thermo_status_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic               down_press     = 1'b0;
    logic               up_press       = 1'b0;
    logic               sensor_valid   = 1'b0;
    logic signed [15:0] sensor_reading = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               heater;
    logic               report;
    logic [7:0]         setpoint;
    logic signed [15:0] ambient;
    logic               remote_lock;

    // Ticks waiting to be sent, and status results waiting to arrive
    tick_t          tick_queue[$];
    thermo_status_t status_q[$];

    int unsigned err_cnt       = 0;
    bit          tick_taken    = 1'b0;
    bit          calm          = 1'b0;   // no idling on either side
    bit          stall_req     = 1'b0;
    bit          stall_started = 1'b0;
    int          hold_left     = 0;

    // Shadow copy of the configuration and control state
    logic [7:0]         cfg_sens = SENSITIVITY_RST;
    logic [7:0]         cfg_min  = SETPOINT_MIN_RST;
    logic [7:0]         cfg_max  = SETPOINT_MAX_RST;
    logic [7:0]         m_setpoint = SETPOINT_RST;
    logic signed [15:0] m_ambient  = '0;
    logic               m_heater   = 1'b0;
    logic               m_lock     = 1'b0;
    logic               m_seen     = 1'b0;

    thermostat_setpoint_and_heater_control DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .down_press     (down_press),
        .up_press       (up_press),
        .sensor_valid   (sensor_valid),
        .sensor_reading (sensor_reading),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .heater         (heater),
        .report         (report),
        .setpoint       (setpoint),
        .ambient        (ambient),
        .remote_lock    (remote_lock)
    );

    always #4 clk = ~clk;

    // Advance the thermostat state by one tick and return the status it shows
    function automatic thermo_status_t predict_status(input tick_t t);
        thermo_status_t s;
        bit             changed;
        int             step_to;
        int             gap;
        int             target;
        changed = 1'b0;
        // Both buttons toggle the lock; one button steps the setpoint
        if (t.down_press && t.up_press)
        begin
            m_lock  = ~m_lock;
            changed = 1'b1;
        end
        else if (t.down_press || t.up_press)
        begin
            step_to = int'(m_setpoint) + (t.up_press ? 1 : -1);
            // minimum wins when the limits are crossed
            if (step_to < int'(cfg_min))
                step_to = int'(cfg_min);
            else if (step_to > int'(cfg_max))
                step_to = int'(cfg_max);
            if (step_to != int'(m_setpoint))
            begin
                m_setpoint = step_to[7:0];
                changed    = 1'b1;
            end
        end
        // Reading must move by more than the sensitivity
        if (t.sensor_valid)
        begin
            gap = int'(m_ambient) - int'(t.sensor_reading);
            if (gap < 0)
                gap = -gap;
            if (gap > int'(cfg_sens))
            begin
                m_ambient = t.sensor_reading;
                m_seen    = 1'b1;
                changed   = 1'b1;
            end
        end
        // Heater with hold band of zero: equal keeps the last level
        target = int'(m_setpoint) * 64;
        if (int'(m_ambient) < target)
        begin
            if (!m_heater)
            begin
                m_heater = 1'b1;
                changed  = 1'b1;
            end
        end
        else if (int'(m_ambient) > target)
        begin
            if (m_heater)
            begin
                m_heater = 1'b0;
                changed  = 1'b1;
            end
        end
        s.heater      = m_heater;
        s.report      = m_seen && changed;
        s.setpoint    = m_setpoint;
        s.ambient     = m_ambient;
        s.remote_lock = m_lock;
        return s;
    endfunction

    function automatic tick_t mk_tick(input logic dn, input logic up, input logic vld,
                                      input logic signed [15:0] rd);
        tick_t t;
        t.down_press     = dn;
        t.up_press       = up;
        t.sensor_valid   = vld;
        t.sensor_reading = rd;
        return t;
    endfunction

    // Register write transaction; shadow copy follows on acceptance
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_SENSITIVITY:  cfg_sens = val;
            CFG_SETPOINT_MIN: cfg_min  = val;
            CFG_SETPOINT_MAX: cfg_max  = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every tick is sent and every status has come back
    task automatic settle();
        while (tick_queue.size() != 0 || status_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Mostly readings near the middle of the setpoint range, some anywhere
    task automatic load_random_ticks(input int n, input int center);
        tick_t       t;
        int          r;
        int          rd;
        bit [31:0]   rnd;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            t.down_press   = (r < 25) || (r >= 92);
            t.up_press     = (r >= 25 && r < 50) || (r >= 92);
            t.sensor_valid = ($urandom_range(99) < 60);
            if ($urandom_range(99) < 15)
            begin
                rnd              = $urandom;
                t.sensor_reading = rnd[15:0];
            end
            else
            begin
                rd               = center + int'($urandom_range(1600)) - 800;
                t.sensor_reading = rd[15:0];
            end
            tick_queue.push_back(t);
        end
    endtask

    // Tick acceptance: predict the status for the transaction just taken
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            status_q.push_back(predict_status({down_press, up_press, sensor_valid,
                                               sensor_reading}));
            void'(tick_queue.pop_front());
            tick_taken = 1'b1;
        end
    end

    // Tick driver: hold until accepted, then offer the next or idle
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || tick_taken)
        begin
            tick_taken = 1'b0;
            if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                {down_press, up_press, sensor_valid, sensor_reading} <= tick_queue[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (stall_req && !stall_started)
        begin
            stall_started = 1'b1;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: compare each status transaction with the oldest prediction
    always @(posedge clk)
    begin
        thermo_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("status transaction with no tick outstanding");
                err_cnt++;
            end
            else
            begin
                want = status_q.pop_front();
                if (heater !== want.heater)
                begin
                    $error("heater: expected %0d, actual %0d", want.heater, heater);
                    err_cnt++;
                end
                if (report !== want.report)
                begin
                    $error("report: expected %0d, actual %0d", want.report, report);
                    err_cnt++;
                end
                if (setpoint !== want.setpoint)
                begin
                    $error("setpoint: expected %0d, actual %0d", want.setpoint, setpoint);
                    err_cnt++;
                end
                if (ambient !== want.ambient)
                begin
                    $error("ambient: expected %0d, actual %0d", want.ambient, ambient);
                    err_cnt++;
                end
                if (remote_lock !== want.remote_lock)
                begin
                    $error("remote_lock: expected %0d, actual %0d",
                           want.remote_lock, remote_lock);
                    err_cnt++;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int unsigned lo;
        int unsigned hi;
        int unsigned sens;
        int unsigned swap;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: buttons, lock, and readings at the extremes
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b0, 1'b1, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b1, 1'b1, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b0, 16'sh7FFF));  // invalid, ignored
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sd10));    // exactly sensitivity
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sd11));    // first reading
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sh7FFF));
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sh8000));  // full-scale swing
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sd2560));  // equals setpoint
        tick_queue.push_back(mk_tick(1'b1, 1'b1, 1'b1, 16'sd2560));
        settle();

        // Narrow window, zero sensitivity, write to the unused index
        write_reg(CFG_SENSITIVITY, 8'd0);
        write_reg(CFG_SETPOINT_MIN, 8'd38);
        write_reg(CFG_SETPOINT_MAX, 8'd41);
        write_reg(CFG_UNUSED, 8'hFF);
        tick_queue.push_back(mk_tick(1'b0, 1'b1, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b0, 1'b1, 1'b0, 16'sd0));     // clamp at max
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b0, 16'sd0));     // clamp at min
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sd2561));  // one LSB moves it
        settle();

        // Minimum above maximum, widest sensitivity
        write_reg(CFG_SENSITIVITY, 8'd255);
        write_reg(CFG_SETPOINT_MIN, 8'd255);
        write_reg(CFG_SETPOINT_MAX, 8'd0);
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b0, 1'b1, 1'b0, 16'sd0));
        tick_queue.push_back(mk_tick(1'b1, 1'b0, 1'b1, 16'sd2816));  // diff 255, ignored
        tick_queue.push_back(mk_tick(1'b0, 1'b0, 1'b1, 16'sd0));
        settle();

        // Random phases, each with its own configuration
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    sens = SENSITIVITY_RST;
                    lo   = SETPOINT_MIN_RST;
                    hi   = SETPOINT_MAX_RST;
                end
                4:
                begin
                    sens = $urandom_range(255);
                    lo   = 0;
                    hi   = 255;
                end
                default:
                begin
                    sens = $urandom_range(60);
                    lo   = $urandom_range(200);
                    hi   = lo + $urandom_range(55);
                    if ($urandom_range(3) == 0)
                    begin
                        swap = lo;
                        lo   = hi;
                        hi   = swap;
                    end
                end
            endcase
            write_reg(CFG_SENSITIVITY, sens[7:0]);
            write_reg(CFG_SETPOINT_MIN, lo[7:0]);
            write_reg(CFG_SETPOINT_MAX, hi[7:0]);
            if (phase == 1)
                stall_req = 1'b1;
            calm = (phase == 3);
            load_random_ticks(100, int'((lo + hi) / 2) * 64);
            settle();
            calm = 1'b0;
        end

        repeat (10) @(posedge clk);
        if (status_q.size() != 0)
        begin
            $error("%0d status transactions never arrived", status_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("thermostat_setpoint_and_heater_control_tb: done, clean");
        else
            $display("thermostat_setpoint_and_heater_control_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(250_000 * 8);
        $display("thermostat_setpoint_and_heater_control_tb: done, errors");
        $finish;
    end

endmodule

### thermostat_setpoint_and_heater_control.f
rtl/thermo_pkg.sv
rtl/thermostat_setpoint_and_heater_control.sv
dv/thermostat_setpoint_and_heater_control_tb.sv
